// File: hw/rtl/rwlm_pkg.sv
// Types and constants shared by the lock manager modules
`default_nettype none
package rwlm_pkg;
    localparam int THREADS = 8;
    localparam int RECORDS = 16;
    localparam int TW      = 3;
    localparam int RW      = 4;
    localparam int CW      = 4;
    localparam int QAW     = RW + TW;

    typedef logic [THREADS-1:0] t_tmask;

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        EV_GRANTED  = 3'd0,
        EV_QUEUED   = 3'd1,
        EV_DEADLOCK = 3'd2,
        EV_WAKE     = 3'd3,
        EV_RELEASED = 3'd4
    } t_ev;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_WALK, S_WENQ, S_DEAD, S_ROLL,
        S_GCHK, S_GRANT, S_GWAIT, S_RET, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        C_NONE, C_LOAD, C_DECODE, C_WALK, C_WENQ, C_DEAD,
        C_ROLL, C_RNEXT, C_GREAD, C_GWAIT, C_FIN
    } t_cmd_op;

    typedef enum logic [2:0] {
        K_IGNORE, K_DONE, K_WALK, K_DEAD, K_GRANT
    } t_kind;

    typedef struct packed {
        t_cmd_op op;
        logic    use_rr;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  walk_hit;
        logic  walk_end;
        logic  roll_hold;
        logic  roll_last;
        logic  holder_nz;
        logic  count_z;
        logic  gw_refuse;
        logic  gw_stop;
    } t_stat;
endpackage
`default_nettype wire

// File: hw/rtl/rwlm_ram.sv
// Generic RAM with one write port and a registered read port
`default_nettype none
module rwlm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/rwlm_ctrl.sv
// Request sequencer of the lock manager
`default_nettype none
module rwlm_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire rwlm_pkg::t_stat i_stat,
    output rwlm_pkg::t_cmd       o_cmd,
    output logic                 o_busy
);
    import rwlm_pkg::*;

    t_state r_state, n_state;
    logic   r_roll, n_roll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_roll  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_roll  <= n_roll;
        end
    end

    always_comb begin
        n_state = r_state;
        n_roll  = r_roll;
        unique case (r_state)
            S_IDLE: begin
                n_roll = 1'b0;
                if (i_start) n_state = S_DECODE;
            end
            S_DECODE: begin
                unique case (i_stat.kind)
                    K_WALK:  n_state = S_WALK;
                    K_DEAD:  n_state = S_DEAD;
                    K_GRANT: n_state = S_GCHK;
                    default: n_state = S_FIN;
                endcase
            end
            S_WALK: begin
                if (i_stat.walk_hit) n_state = S_DEAD;
                else if (i_stat.walk_end) n_state = S_WENQ;
            end
            S_WENQ: n_state = S_FIN;
            S_DEAD: begin
                n_roll  = 1'b1;
                n_state = S_ROLL;
            end
            S_ROLL: begin
                if (i_stat.roll_hold) n_state = S_GCHK;
                else if (i_stat.roll_last) n_state = S_FIN;
            end
            S_GCHK:  n_state = i_stat.holder_nz ? S_RET : S_GRANT;
            S_GRANT: n_state = i_stat.count_z ? S_RET : S_GWAIT;
            S_GWAIT: begin
                if (i_stat.gw_refuse || i_stat.gw_stop) n_state = S_RET;
                else n_state = S_GRANT;
            end
            S_RET:   n_state = (r_roll && !i_stat.roll_last) ? S_ROLL : S_FIN;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.use_rr = r_roll;
        o_busy       = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:   o_cmd.op = i_start ? C_LOAD : C_NONE;
            S_DECODE: o_cmd.op = C_DECODE;
            S_WALK:   o_cmd.op = C_WALK;
            S_WENQ:   o_cmd.op = C_WENQ;
            S_DEAD:   o_cmd.op = C_DEAD;
            S_ROLL:   o_cmd.op = C_ROLL;
            S_GRANT:  o_cmd.op = i_stat.count_z ? C_NONE : C_GREAD;
            S_GWAIT:  o_cmd.op = C_GWAIT;
            S_RET:    o_cmd.op = (r_roll && !i_stat.roll_last) ? C_RNEXT : C_NONE;
            S_FIN:    o_cmd.op = C_FIN;
            default:  o_cmd.op = C_NONE;
        endcase
    end

    a_gwait_after_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GWAIT) |-> ($past(r_state) == S_GRANT))
        else $error("grant wait entered without a queue read");
endmodule
`default_nettype wire

// File: hw/rtl/rwlm_dp.sv
// Lock table, wait queues, wait-for walk and result staging
`default_nettype none
module rwlm_dp (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire rwlm_pkg::t_cmd         i_cmd,
    input  wire logic [1:0]             i_opcode,
    input  wire logic [rwlm_pkg::TW-1:0] i_thread_id,
    input  wire logic [rwlm_pkg::RW-1:0] i_record_id,
    output rwlm_pkg::t_stat             o_stat,
    output logic                        o_valid,
    output logic [2:0]                  o_event_res,
    output logic [rwlm_pkg::TW-1:0]     o_thread_id_out,
    output logic [rwlm_pkg::RW-1:0]     o_record_id_out,
    output logic                        o_last
);
    import rwlm_pkg::*;

    t_tmask        r_hm   [RECORDS];
    logic          r_wh   [RECORDS];
    logic [TW-1:0] r_head [RECORDS];
    logic [CW-1:0] r_cnt  [RECORDS];
    logic [CW-1:0] r_wqc  [RECORDS];
    logic          r_wov  [THREADS];
    logic [RW-1:0] r_wor  [THREADS];

    t_op           r_op;
    logic [TW-1:0] r_t;
    logic [RW-1:0] r_rec;
    logic [RW-1:0] r_rr;
    logic [TW-1:0] r_h;
    t_tmask        r_vis, r_front, r_next;

    logic          r_pv;
    t_ev           r_pev;
    logic [TW-1:0] r_pt;
    logic [RW-1:0] r_pr;

    logic [RW-1:0] sel;
    t_tmask        hm, tbit, nxt;
    logic          wh, holds, full, wv, hit, last_h;
    logic [TW-1:0] head, tail;
    logic [CW-1:0] cnt, wqc;
    logic [3:0]    ram_q;
    logic [TW-1:0] gw_w;
    logic          gw_rd, gw_refuse;

    t_kind         kind;
    logic          e_we, n_wh;
    t_tmask        n_hm;
    logic [TW-1:0] n_head;
    logic [CW-1:0] n_cnt, n_wqc;
    logic          wo_we, wo_v;
    logic [TW-1:0] wo_idx;
    logic          ram_we;
    logic [QAW-1:0] ram_addr;
    logic [3:0]    ram_d;
    logic          emit, fin;
    t_ev           em_ev;
    logic [TW-1:0] em_t;

    assign sel    = (i_cmd.op == C_WALK) ? r_wor[r_h] : (i_cmd.use_rr ? r_rr : r_rec);
    assign hm     = r_hm[sel];
    assign wh     = r_wh[sel];
    assign head   = r_head[sel];
    assign cnt    = r_cnt[sel];
    assign wqc    = r_wqc[sel];
    assign tbit   = t_tmask'(1) << r_t;
    assign holds  = hm[r_t];
    assign full   = (cnt >= CW'(THREADS));
    assign tail   = head + cnt[TW-1:0];
    assign gw_w   = ram_q[3:1];
    assign gw_rd  = ram_q[0];
    assign gw_refuse = !gw_rd && (hm != '0);
    assign wv     = r_front[r_h] && r_wov[r_h];
    assign hit    = wv && hm[r_t];
    assign nxt    = r_next | (wv ? (hm & ~r_vis) : '0);
    assign last_h = (r_h == TW'(THREADS - 1));
    assign fin    = (i_cmd.op == C_FIN);

    always_comb begin
        kind     = K_DONE;
        e_we     = 1'b0;
        n_hm     = hm;
        n_wh     = wh;
        n_head   = head;
        n_cnt    = cnt;
        n_wqc    = wqc;
        wo_we    = 1'b0;
        wo_v     = 1'b0;
        wo_idx   = r_t;
        ram_we   = 1'b0;
        ram_addr = {sel, head};
        ram_d    = {r_t, 1'b0};
        emit     = 1'b0;
        em_ev    = EV_GRANTED;
        em_t     = r_t;
        unique case (i_cmd.op)
            C_DECODE: begin
                if (r_op == OP_NONE || r_wov[r_t]) begin
                    kind = K_IGNORE;
                end else begin
                    unique case (r_op)
                        OP_READ: begin
                            if (holds) begin
                                emit = 1'b1;
                            end else if (!wh && wqc == '0) begin
                                e_we = 1'b1;
                                n_hm = hm | tbit;
                                emit = 1'b1;
                            end else if (full) begin
                                kind = K_IGNORE;
                            end else begin
                                e_we     = 1'b1;
                                n_cnt    = cnt + 1'b1;
                                ram_we   = 1'b1;
                                ram_addr = {sel, tail};
                                ram_d    = {r_t, 1'b1};
                                wo_we    = 1'b1;
                                wo_v     = 1'b1;
                                emit     = 1'b1;
                                em_ev    = EV_QUEUED;
                            end
                        end
                        OP_WRITE: begin
                            if (holds && wh) begin
                                emit = 1'b1;
                            end else if (holds) begin
                                kind = K_DEAD;
                            end else if (hm == '0 && cnt == '0) begin
                                e_we = 1'b1;
                                n_hm = hm | tbit;
                                n_wh = 1'b1;
                                emit = 1'b1;
                            end else begin
                                kind = K_WALK;
                            end
                        end
                        OP_RELEASE: begin
                            if (!holds) begin
                                kind = K_IGNORE;
                            end else begin
                                e_we  = 1'b1;
                                n_hm  = hm & ~tbit;
                                n_wh  = 1'b0;
                                emit  = 1'b1;
                                em_ev = EV_RELEASED;
                                kind  = K_GRANT;
                            end
                        end
                        default: kind = K_IGNORE;
                    endcase
                end
            end
            C_WENQ: begin
                if (!full) begin
                    e_we     = 1'b1;
                    n_cnt    = cnt + 1'b1;
                    n_wqc    = wqc + 1'b1;
                    ram_we   = 1'b1;
                    ram_addr = {sel, tail};
                    ram_d    = {r_t, 1'b0};
                    wo_we    = 1'b1;
                    wo_v     = 1'b1;
                    emit     = 1'b1;
                    em_ev    = EV_QUEUED;
                end
            end
            C_DEAD: begin
                emit  = 1'b1;
                em_ev = EV_DEADLOCK;
            end
            C_ROLL: begin
                if (holds) begin
                    e_we = 1'b1;
                    n_hm = hm & ~tbit;
                    n_wh = 1'b0;
                end
            end
            C_GWAIT: begin
                if (!gw_refuse) begin
                    e_we   = 1'b1;
                    n_head = head + 1'b1;
                    n_cnt  = cnt - 1'b1;
                    n_hm   = hm | (t_tmask'(1) << gw_w);
                    if (!gw_rd) begin
                        n_wh  = 1'b1;
                        n_wqc = wqc - 1'b1;
                    end
                    wo_we  = 1'b1;
                    wo_idx = gw_w;
                    emit   = 1'b1;
                    em_ev  = EV_WAKE;
                    em_t   = gw_w;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.kind      = kind;
        o_stat.walk_hit  = hit;
        o_stat.walk_end  = last_h && !hit && (nxt == '0);
        o_stat.roll_hold = holds;
        o_stat.roll_last = (r_rr == RW'(RECORDS - 1));
        o_stat.holder_nz = (hm != '0);
        o_stat.count_z   = (cnt == '0);
        o_stat.gw_refuse = gw_refuse;
        o_stat.gw_stop   = !gw_rd || (cnt == CW'(1));
    end

    rwlm_ram #(.WIDTH(4), .DEPTH(RECORDS * THREADS)) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_d),
        .i_raddr (ram_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RECORDS; i++) begin
                r_hm[i]   <= '0;
                r_wh[i]   <= 1'b0;
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
                r_wqc[i]  <= '0;
            end
            for (int i = 0; i < THREADS; i++) begin
                r_wov[i] <= 1'b0;
            end
            r_pv    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (e_we) begin
                r_hm[sel]   <= n_hm;
                r_wh[sel]   <= n_wh;
                r_head[sel] <= n_head;
                r_cnt[sel]  <= n_cnt;
                r_wqc[sel]  <= n_wqc;
            end
            if (wo_we) begin
                r_wov[wo_idx] <= wo_v;
            end
            o_valid <= r_pv && (emit || fin);
            if (emit) begin
                r_pv <= 1'b1;
            end else if (fin) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wo_we && wo_v) begin
            r_wor[wo_idx] <= sel;
        end
        if (i_cmd.op == C_LOAD) begin
            r_op  <= t_op'(i_opcode);
            r_t   <= i_thread_id;
            r_rec <= i_record_id;
        end
        if (i_cmd.op == C_DECODE) begin
            r_vis   <= hm;
            r_front <= hm;
            r_next  <= '0;
            r_h     <= '0;
        end
        if (i_cmd.op == C_WALK) begin
            r_h <= r_h + 1'b1;
            if (last_h) begin
                r_vis   <= r_vis | nxt;
                r_front <= nxt;
                r_next  <= '0;
            end else begin
                r_next <= nxt;
            end
        end
        if (i_cmd.op == C_DEAD) begin
            r_rr <= '0;
        end else if (i_cmd.op == C_RNEXT || (i_cmd.op == C_ROLL && !holds)) begin
            r_rr <= r_rr + 1'b1;
        end
        if (r_pv && (emit || fin)) begin
            o_event_res     <= r_pev;
            o_thread_id_out <= r_pt;
            o_record_id_out <= r_pr;
            o_last          <= fin;
        end
        if (emit) begin
            r_pev <= em_ev;
            r_pt  <= em_t;
            r_pr  <= sel;
        end
    end

    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result directly after a final result");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        e_we |-> (n_cnt <= CW'(THREADS)))
        else $error("wait queue count beyond thread count");

    a_fin_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin |=> !r_pv)
        else $error("staged result kept across request end");
endmodule
`default_nettype wire

// File: hw/rtl/reader_writer_lock_manager.sv
// Top level of the shared/exclusive lock manager with wait queues
//
// channel   | signals                                    | direction
// ----------+--------------------------------------------+----------
// request   | start, busy (out), i_opcode, i_thread_id,  | in
//           | i_record_id                                |
// result    | o_valid, o_event_res, o_thread_id_out,     | out
//           | o_record_id_out, o_last                    |
//
// A request is taken when start is high and busy is low; its last result is on
// the ports in the first idle cycle after busy falls. A release that frees a
// record wakes its waiters from the queue head; each woken waiter takes a queue
// RAM read then a grant in place of the empty-queue check, and a queued writer
// that stops a run of readers adds a further read and a refused grant. A writer
// that would wait walks the wait-for graph one thread per cycle, round by round;
// a deadlock refusal scans all 16 records one per cycle while a record is not
// held, and releases each held record and wakes its waiters. Results are
// strobes of one cycle on o_valid and cannot be stalled. Reset clears all lock
// state at once; no clearing pass.
`default_nettype none
module reader_writer_lock_manager (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_opcode,
    input  wire logic [2:0] i_thread_id,
    input  wire logic [3:0] i_record_id,
    output logic            o_valid,
    output logic [2:0]      o_event_res,
    output logic [2:0]      o_thread_id_out,
    output logic [3:0]      o_record_id_out,
    output logic            o_last
);
    import rwlm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    rwlm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    rwlm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_opcode        (i_opcode),
        .i_thread_id     (i_thread_id),
        .i_record_id     (i_record_id),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_event_res     (o_event_res),
        .o_thread_id_out (o_thread_id_out),
        .o_record_id_out (o_record_id_out),
        .o_last          (o_last)
    );
endmodule
`default_nettype wire
